>>> design/gb5_pkg.sv
// shared constants and types of the 5x5 gaussian blur stream unit
package gb5_pkg;

  localparam int MaxWidth  = 2048;
  localparam int ColW      = $clog2(MaxWidth);
  localparam int RowW      = 16;
  localparam int FwW       = 12;
  localparam int PixW      = 24;
  localparam int VsumW     = 12;
  localparam int SumW      = 15;
  localparam int OutDataW  = 56;
  localparam int FifoDepth = 8;
  localparam int FifoAw    = $clog2(FifoDepth);
  localparam int RecipMul  = 5243;
  localparam int RecipSh   = 19;
  localparam int MaxResults = 9;

  localparam logic [0:0] RegFrameWidth  = 1'd0;
  localparam logic [0:0] RegFrameHeight = 1'd1;

  localparam logic [FwW-1:0]  FwReset = 12'd640;
  localparam logic [RowW-1:0] FhReset = 16'd480;

  typedef struct packed {
    logic [RowW-1:0] rlo;
    logic [RowW-1:0] rhi;
    logic [ColW-1:0] clo;
    logic [ColW-1:0] chi;
  } span_t;

  typedef struct packed {
    span_t      span;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } desc_t;

endpackage

>>> design/gb5_ram.sv
// generic single-port-write, registered-read ram
module gb5_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> design/gaussian_blur_5x5_stream_unit.sv
// top level of the 5x5 gaussian blur stream unit
//
// channel  | dir | fields
// s_axis   | in  | tdata: blue_in, green_in, red_in
// m_axis   | out | tdata: out_row, out_col, blue_out, green_out, red_out; tlast: run_last
// cfg      | in  | cfg_index 0 frame_width, 1 frame_height; cfg_data
//
// one pixel per cycle in while s_axis_tready is high; three pipeline stages from request to the result queue
// the first result of a request passes stages 1 to 3, the result queue and the output register
// the line memory (four rows per column) is read and written back once per pixel
// border copies leave one result per cycle while m_axis_tready is high; input stalls once queue and stages hold eight
// reset clears counters, window and queue; line memory holds garbage until written
module gaussian_blur_5x5_stream_unit
  import gb5_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [PixW-1:0]     s_axis_tdata,   // blue_in, green_in, red_in
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [OutDataW-1:0] m_axis_tdata,   // out_row, out_col, blue_out, green_out, red_out
  output logic                m_axis_tlast,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [7:0]          cfg_index,
  input  logic [RowW-1:0]     cfg_data
);

  logic [FwW-1:0]  frame_width;
  logic [RowW-1:0] frame_height;
  logic [FwW-1:0]  eff_w;
  logic [RowW-1:0] eff_h;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= FwReset;
      frame_height <= FhReset;
    end else if (cfg_valid) begin
      if (cfg_index == 8'(RegFrameWidth)) begin
        frame_width <= cfg_data[FwW-1:0];
      end else if (cfg_index == 8'(RegFrameHeight)) begin
        frame_height <= cfg_data;
      end
    end
  end

  always_comb begin
    eff_w = frame_width;
    if (frame_width < FwW'(5)) eff_w = FwW'(5);
    if (frame_width > FwW'(MaxWidth)) eff_w = FwW'(MaxWidth);
    eff_h = (frame_height < RowW'(5)) ? RowW'(5) : frame_height;
  end

  // position counters
  logic [RowW-1:0] in_row, row0, row_next;
  logic [ColW-1:0] in_col, col0, col_next;
  logic            wrap_c;
  logic [RowW:0]   row_inc, row_inc2;
  logic [FwW-1:0]  col_inc;
  logic            accept;

  logic [4:0]         fifo_count;
  logic               s1_valid, s2_valid, s3_valid;

  assign s_axis_tready = (5'(fifo_count) + 5'(s1_valid) + 5'(s2_valid) + 5'(s3_valid))
                         < 5'(FifoDepth);
  assign accept = s_axis_tvalid && s_axis_tready;

  always_comb begin
    wrap_c   = {1'b0, in_col} >= eff_w;
    col0     = wrap_c ? '0 : in_col;
    row_inc  = {1'b0, in_row} + (RowW+1)'(wrap_c);
    row0     = (row_inc >= {1'b0, eff_h}) ? '0 : row_inc[RowW-1:0];
    col_inc  = {1'b0, col0} + FwW'(1);
    row_inc2 = {1'b0, row0} + (RowW+1)'(1);
    if (col_inc >= eff_w) begin
      col_next = '0;
      row_next = (row_inc2 >= {1'b0, eff_h}) ? '0 : row_inc2[RowW-1:0];
    end else begin
      col_next = col_inc[ColW-1:0];
      row_next = row0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_row <= '0;
      in_col <= '0;
    end else if (accept) begin
      in_row <= row_next;
      in_col <= col_next;
    end
  end

  // stage 1: line memory data back, vertical sum, write back
  logic [PixW-1:0]   s1_pix;
  logic [RowW-1:0]   s1_row;
  logic [ColW-1:0]   s1_col;
  logic              s1_emit;
  logic [4*PixW-1:0] line_rd, line_wr;
  logic [VsumW-1:0]  vsum [3];
  logic [VsumW-1:0]  win [5][3];

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
    end
    s1_pix  <= s_axis_tdata;
    s1_row  <= row0;
    s1_col  <= col0;
    s1_emit <= (row0 >= RowW'(4)) && (col0 >= ColW'(4));
  end

  gb5_ram #(.WIDTH(4*PixW), .DEPTH(MaxWidth)) u_line_ram (
    .clk     (clk),
    .wr_en   (s1_valid),
    .wr_addr (s1_col),
    .wr_data (line_wr),
    .rd_en   (accept),
    .rd_addr (col0),
    .rd_data (line_rd)
  );

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      vsum[ch] = VsumW'(s1_pix[8*ch +: 8])
               + VsumW'(line_rd[8*ch +: 8])
               + (VsumW'(line_rd[PixW + 8*ch +: 8]) << 1)
               + (VsumW'(line_rd[2*PixW + 8*ch +: 8]) << 2)
               + (VsumW'(line_rd[3*PixW + 8*ch +: 8]) << 1);
    end
    line_wr = {s1_pix, line_rd[4*PixW-1:PixW]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < 5; k++) begin
        for (int ch = 0; ch < 3; ch++) begin
          win[k][ch] <= '0;
        end
      end
    end else if (s1_valid) begin
      for (int k = 0; k < 4; k++) begin
        for (int ch = 0; ch < 3; ch++) begin
          win[k][ch] <= win[k+1][ch];
        end
      end
      for (int ch = 0; ch < 3; ch++) begin
        win[4][ch] <= vsum[ch];
      end
    end
  end

  // border span of the centre pixel
  logic [RowW-1:0] cen_r;
  logic [ColW-1:0] cen_c;
  span_t           s1_span;

  always_comb begin
    cen_r = s1_row - RowW'(2);
    cen_c = s1_col - ColW'(2);
    s1_span.rlo = (cen_r == RowW'(2)) ? '0 : cen_r;
    s1_span.rhi = (cen_r == eff_h - RowW'(3)) ? eff_h - RowW'(1) : cen_r;
    s1_span.clo = (cen_c == ColW'(2)) ? '0 : cen_c;
    s1_span.chi = ({1'b0, cen_c} == eff_w - FwW'(3)) ? ColW'(eff_w - FwW'(1)) : cen_c;
  end

  // stage 2: horizontal sum
  span_t          s2_span, s3_span;
  logic           s2_emit, s3_emit;
  logic [SumW-1:0] hsum [3];
  logic [SumW-1:0] s3_sum [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
    end else begin
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
    end
    s2_span <= s1_span;
    s2_emit <= s1_emit;
    s3_span <= s2_span;
    s3_emit <= s2_emit;
    for (int ch = 0; ch < 3; ch++) begin
      s3_sum[ch] <= hsum[ch];
    end
  end

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      hsum[ch] = SumW'(win[0][ch]) + (SumW'(win[1][ch]) << 1) + (SumW'(win[2][ch]) << 2)
               + (SumW'(win[3][ch]) << 1) + SumW'(win[4][ch]);
    end
  end

  // stage 3: divide by 100 through the reciprocal
  logic [SumW+13-1:0] prod [3];
  desc_t              push_desc;

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      prod[ch] = (SumW+13)'(s3_sum[ch]) * (SumW+13)'(RecipMul);
    end
    push_desc.span  = s3_span;
    push_desc.blue  = prod[0][RecipSh +: 8];
    push_desc.green = prod[1][RecipSh +: 8];
    push_desc.red   = prod[2][RecipSh +: 8];
  end

  // result queue
  desc_t             fifo_mem [FifoDepth];
  logic [FifoAw-1:0] wr_ptr, rd_ptr;
  logic              push, pop;
  desc_t             head;

  assign push = s3_valid && s3_emit;
  assign head = fifo_mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_mem[wr_ptr] <= push_desc;
    end
    if (rst) begin
      wr_ptr     <= '0;
      rd_ptr     <= '0;
      fifo_count <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + FifoAw'(1);
      if (pop) rd_ptr <= rd_ptr + FifoAw'(1);
      fifo_count <= fifo_count + 5'(push) - 5'(pop);
    end
  end

  // emitter: walks the border span of the head entry
  logic            started;
  logic [RowW-1:0] cur_row, sel_row;
  logic [ColW-1:0] cur_col, sel_col;
  logic [3:0]      cur_n, sel_n;
  logic            sel_last, load;

  assign load = (fifo_count != '0) && (!m_axis_tvalid || m_axis_tready);
  assign pop  = load && sel_last;

  always_comb begin
    sel_row  = started ? cur_row : head.span.rlo;
    sel_col  = started ? cur_col : head.span.clo;
    sel_n    = started ? cur_n : '0;
    sel_last = ((sel_row == head.span.rhi) && (sel_col == head.span.chi))
            || (sel_n == 4'(MaxResults - 1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
      started       <= 1'b0;
    end else begin
      if (load) begin
        m_axis_tvalid <= 1'b1;
        started       <= !sel_last;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
    if (load) begin
      m_axis_tdata <= {5'b0, head.red, head.green, head.blue, sel_col, sel_row};
      m_axis_tlast <= sel_last;
      cur_n        <= sel_n + 4'(1);
      if (sel_col == head.span.chi) begin
        cur_row <= sel_row + RowW'(1);
        cur_col <= head.span.clo;
      end else begin
        cur_row <= sel_row;
        cur_col <= sel_col + ColW'(1);
      end
    end
  end

endmodule

>>> design/gb5_checker.sv
// port-level checks of the blur unit, bound to the top level
module gb5_checker
  import gb5_pkg::*;
(
  input logic                clk,
  input logic                rst,
  input logic                s_axis_tvalid,
  input logic                s_axis_tready,
  input logic                m_axis_tvalid,
  input logic                m_axis_tready,
  input logic [OutDataW-1:0] m_axis_tdata,
  input logic                m_axis_tlast,
  input logic                cfg_valid,
  input logic                cfg_ready
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tlast))
    else $error("stalled result changed");

  a_reset_idle: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result valid after reset");

  a_pad_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[OutDataW-1:51] == '0)
    else $error("tdata padding not zero");

  a_cfg_ready: assert property (@(posedge clk) disable iff (rst)
    cfg_valid |-> cfg_ready)
    else $error("config request refused");

  a_ready_known: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid |-> !$isunknown(s_axis_tready))
    else $error("input ready unknown");

endmodule

bind gaussian_blur_5x5_stream_unit gb5_checker u_gb5_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast),
  .cfg_valid     (cfg_valid),
  .cfg_ready     (cfg_ready)
);
